@@ src/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Types and codes shared by the priority scheduler modules.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int ID_W   = 4;
  localparam int PRIO_W = 8;
  localparam int LEN_W  = 16;
  localparam int WAIT_W = 16;

  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

  localparam logic FN_ADMIT = 1'b0;
  localparam logic FN_TICK  = 1'b1;

  localparam logic [1:0] ST_ADMIT  = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_IDLE   = 2'd2;
  localparam logic [1:0] ST_RAN    = 2'd3;

  typedef struct packed {
    logic              func;
    logic [ID_W-1:0]   task_id;
    logic [LEN_W-1:0]  burst_len;
    logic [PRIO_W-1:0] task_prio;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   run_id;
    logic              finished;
    logic [WAIT_W-1:0] wait_total;
    logic [4:0]        ready_count;
  } out_t;

  typedef struct packed {
    logic admit;
    logic tick;
    logic run;
  } slot_ctl_t;

endpackage

@@ src/pps_slot.sv @@
// ----------------------------------------------------------------------------
// pps_slot
// One task slot: ready flag, priority, remaining burst and wait count.
// ----------------------------------------------------------------------------
module pps_slot
  import pps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  slot_ctl_t         ctl,
  input  logic [LEN_W-1:0]  burst_in,
  input  logic [PRIO_W-1:0] prio_in,
  output logic              ready,
  output logic [PRIO_W-1:0] prio,
  output logic [LEN_W-1:0]  left,
  output logic [WAIT_W-1:0] wait_cnt
);

  logic              ready_r, ready_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [WAIT_W-1:0] wait_cnt_r, wait_cnt_nxt;
  logic              last;

  assign last = (left_r <= LEN_W'(1));

  always_comb begin
    ready_nxt    = ready_r;
    prio_nxt     = prio_r;
    left_nxt     = left_r;
    wait_cnt_nxt = wait_cnt_r;
    if (ctl.admit) begin
      ready_nxt    = 1'b1;
      prio_nxt     = prio_in;
      left_nxt     = (burst_in == '0) ? LEN_W'(1) : burst_in;
      wait_cnt_nxt = '0;
    end else if (ctl.tick && ctl.run) begin
      if (last) begin
        ready_nxt = 1'b0;
        left_nxt  = '0;
      end else begin
        left_nxt = left_r - LEN_W'(1);
      end
    end else if (ctl.tick && ready_r && (wait_cnt_r != WAIT_MAX)) begin
      wait_cnt_nxt = wait_cnt_r + WAIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else begin
      ready_r <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r     <= prio_nxt;
    left_r     <= left_nxt;
    wait_cnt_r <= wait_cnt_nxt;
  end

  assign ready    = ready_r;
  assign prio     = prio_r;
  assign left     = left_r;
  assign wait_cnt = wait_cnt_r;

endmodule

@@ src/pps_pick.sv @@
// ----------------------------------------------------------------------------
// pps_pick
// Highest priority ready slot; lowest id on a tie, running task kept on a tie.
// ----------------------------------------------------------------------------
module pps_pick
  import pps_pkg::*;
#(
  parameter int N = 16
)
(
  input  logic              ready [N],
  input  logic [PRIO_W-1:0] prio  [N],
  input  logic [ID_W-1:0]   cur_id,
  input  logic              cur_valid,
  output logic              found,
  output logic [$clog2(N)-1:0] best,
  output logic [N-1:0]      run
);

  localparam int IW = $clog2(N);
  localparam int P  = 1 << IW;

  logic              nv [2*P-1];
  logic [PRIO_W-1:0] np [2*P-1];
  logic [IW-1:0]     ni [2*P-1];
  logic              cur_ok;

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign nv[P-1+i] = ready[i];
      assign np[P-1+i] = prio[i];
    end else begin : g_pad
      assign nv[P-1+i] = 1'b0;
      assign np[P-1+i] = '0;
    end
    assign ni[P-1+i] = IW'(i);
  end

  // left child holds the lower ids, so >= keeps the lowest id on a tie
  for (genvar k = 0; k < P-1; k++) begin : g_node
    logic take_l;
    assign take_l = nv[2*k+1] && (!nv[2*k+2] || (np[2*k+1] >= np[2*k+2]));
    assign nv[k]  = nv[2*k+1] || nv[2*k+2];
    assign np[k]  = take_l ? np[2*k+1] : np[2*k+2];
    assign ni[k]  = take_l ? ni[2*k+1] : ni[2*k+2];
  end

  assign cur_ok = cur_valid && (32'(cur_id) < N) && ready[cur_id[IW-1:0]] &&
                  (prio[cur_id[IW-1:0]] == np[0]);

  assign found = nv[0];
  assign best  = cur_ok ? cur_id[IW-1:0] : ni[0];

  for (genvar i = 0; i < N; i++) begin : g_run
    assign run[i] = found && (best == IW'(i));
  end

endmodule

@@ src/preemptive_priority_scheduler.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle; busy is never raised. The item is
// registered on the edge that accepts it, the slot table is read and the
// winner chosen in the following cycle; the result and its strobe out_valid
// are registered from it; out_valid is high for a single cycle per result.
// The rate is one item per cycle, set by the combinational priority tree and
// slot update; the next item sees the table as left by the one before it.
// Results cannot be held off, so each must be captured when out_valid is high.
// Slots with an id of MAX_TASKS or above (or above 15) reject admits.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = 16
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  in_t  in_data,
  output logic busy,
  output logic out_valid,
  output out_t out_data
);

  localparam int NSLOT = (MAX_TASKS < (1 << ID_W)) ? MAX_TASKS : (1 << ID_W);
  localparam int IW    = $clog2(NSLOT);
  localparam int CW    = $clog2(NSLOT + 1);

  in_t             in_r;
  logic            in_vld_r;
  out_t            out_r, out_nxt;
  logic            out_vld_r;
  logic [ID_W-1:0] cur_task_r, cur_task_nxt;
  logic            cur_vld_r, cur_vld_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  logic              ready_a [NSLOT];
  logic [PRIO_W-1:0] prio_a  [NSLOT];
  logic [LEN_W-1:0]  left_a  [NSLOT];
  logic [WAIT_W-1:0] wait_a  [NSLOT];
  logic [NSLOT-1:0]  ready_v;

  logic            found;
  logic [IW-1:0]   best;
  logic [NSLOT-1:0] run;

  logic            id_ok, admit_ok, tick_go, fin;
  logic [LEN_W-1:0]  run_left;
  logic [WAIT_W-1:0] run_wait;

  assign busy = 1'b0;

  assign id_ok    = (32'(in_r.task_id) < NSLOT) && !ready_a[in_r.task_id[IW-1:0]];
  assign admit_ok = in_vld_r && (in_r.func == FN_ADMIT) && id_ok;
  assign tick_go  = in_vld_r && (in_r.func == FN_TICK) && found;

  pps_pick #(.N(NSLOT)) u_pick (
    .ready     (ready_a),
    .prio      (prio_a),
    .cur_id    (cur_task_r),
    .cur_valid (cur_vld_r),
    .found     (found),
    .best      (best),
    .run       (run)
  );

  for (genvar i = 0; i < NSLOT; i++) begin : g_slot
    slot_ctl_t ctl;
    assign ctl.admit  = admit_ok && (in_r.task_id == ID_W'(i));
    assign ctl.tick   = tick_go;
    assign ctl.run    = run[i];
    assign ready_v[i] = ready_a[i];

    pps_slot u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .burst_in (in_r.burst_len),
      .prio_in  (in_r.task_prio),
      .ready    (ready_a[i]),
      .prio     (prio_a[i]),
      .left     (left_a[i]),
      .wait_cnt (wait_a[i])
    );
  end

  always_comb begin
    run_left = '0;
    run_wait = '0;
    for (int i = 0; i < NSLOT; i++) begin
      run_left = run_left | (left_a[i] & {LEN_W{run[i]}});
      run_wait = run_wait | (wait_a[i] & {WAIT_W{run[i]}});
    end
  end

  assign fin = tick_go && (run_left <= LEN_W'(1));

  always_comb begin
    cnt_nxt = cnt_r;
    if (admit_ok) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (fin) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    cur_task_nxt = cur_task_r;
    cur_vld_nxt  = cur_vld_r;
    if (tick_go) begin
      cur_task_nxt = ID_W'(best);
      cur_vld_nxt  = !fin;
    end
  end

  always_comb begin
    out_nxt             = '0;
    out_nxt.ready_count = 5'(cnt_nxt);
    if (in_r.func == FN_ADMIT) begin
      out_nxt.status = admit_ok ? ST_ADMIT : ST_REJECT;
    end else if (!found) begin
      out_nxt.status = ST_IDLE;
    end else begin
      out_nxt.status   = ST_RAN;
      out_nxt.run_id   = ID_W'(best);
      out_nxt.finished = fin;
      if (fin) begin
        out_nxt.wait_total = run_wait;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      cur_task_r <= '0;
      cur_vld_r  <= 1'b0;
      cnt_r      <= '0;
    end else begin
      in_vld_r   <= start && !busy;
      out_vld_r  <= in_vld_r;
      cur_task_r <= cur_task_nxt;
      cur_vld_r  <= cur_vld_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
    if (in_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  logic cur_rdy, out_rdy;
  assign cur_rdy = (32'(cur_task_r) < NSLOT) && ready_a[cur_task_r[IW-1:0]];
  assign out_rdy = (32'(out_r.run_id) < NSLOT) && ready_a[out_r.run_id[IW-1:0]];

  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) == $countones(ready_v))
    else $error("ready counter differs from ready flags");

  a_cur_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> cur_rdy)
    else $error("running task not ready");

  a_fin_gone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_r.status == ST_RAN) && out_r.finished |-> !out_rdy)
    else $error("finished task still ready");

  a_run_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(run) && (found == (run != '0)))
    else $error("run select not one-hot");
`endif

endmodule

@@ sim/preemptive_priority_scheduler_chk.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_chk
// Result checker for the preemptive priority scheduler.
// Watches the command and result channels, keeps its own copy of the task
// table, predicts the result of every accepted transfer and compares each
// strobed result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_chk
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = 16
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_valid,
  input  out_t out_data,
  output int   fail_count,
  output int   pending
);

  localparam int SLOTS = 2 ** ID_W;

  logic [SLOTS-1:0]  ready_tab;
  logic [PRIO_W-1:0] prio_tab [SLOTS];
  logic [LEN_W-1:0]  left_tab [SLOTS];
  logic [WAIT_W-1:0] wait_tab [SLOTS];
  logic [ID_W-1:0]   running_id;
  logic              running_on;

  out_t due_results [$];
  int   fails = 0;

  function automatic out_t schedule_item(in_t it);
    out_t r;
    logic found;
    int   best;
    int   n;
    r     = '0;
    found = 1'b0;
    best  = 0;
    n     = 0;
    if (it.func == FN_ADMIT) begin
      if (int'(it.task_id) >= MAX_TASKS || ready_tab[it.task_id]) begin
        r.status = ST_REJECT;
      end else begin
        ready_tab[it.task_id] = 1'b1;
        prio_tab[it.task_id]  = it.task_prio;
        left_tab[it.task_id]  = (it.burst_len == '0) ? LEN_W'(1) : it.burst_len;
        wait_tab[it.task_id]  = '0;
        r.status              = ST_ADMIT;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (ready_tab[i] && (!found || prio_tab[i] > prio_tab[best])) begin
          best  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        r.status = ST_IDLE;
      end else begin
        // running task keeps the CPU on a tie
        if (running_on && ready_tab[running_id] && prio_tab[running_id] == prio_tab[best])
          best = int'(running_id);
        for (int i = 0; i < SLOTS; i++) begin
          if (i != best && ready_tab[i] && wait_tab[i] != WAIT_MAX)
            wait_tab[i] = wait_tab[i] + 1'b1;
        end
        r.status = ST_RAN;
        r.run_id = best[ID_W-1:0];
        if (left_tab[best] <= LEN_W'(1)) begin
          left_tab[best]  = '0;
          ready_tab[best] = 1'b0;
          r.finished      = 1'b1;
          r.wait_total    = wait_tab[best];
          running_on      = 1'b0;
        end else begin
          left_tab[best] = left_tab[best] - 1'b1;
          running_on     = 1'b1;
        end
        running_id = best[ID_W-1:0];
      end
    end
    for (int i = 0; i < SLOTS; i++)
      n += int'(ready_tab[i]);
    r.ready_count = n[4:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fails++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      ready_tab  = '0;
      running_id = '0;
      running_on = 1'b0;
      due_results.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        if (due_results.size() == 0) begin
          fails++;
          $error("result strobe with no transfer outstanding");
        end else begin
          want = due_results.pop_front();
          check_field("status",      16'(want.status),      16'(out_data.status));
          check_field("run_id",      16'(want.run_id),      16'(out_data.run_id));
          check_field("finished",    16'(want.finished),    16'(out_data.finished));
          check_field("wait_total",  want.wait_total,       out_data.wait_total);
          check_field("ready_count", 16'(want.ready_count), 16'(out_data.ready_count));
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        due_results.push_back(schedule_item(in_data));
    end
    fail_count <= fails;
    pending    <= due_results.size();
  end

endmodule

@@ sim/preemptive_priority_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_tb
// Testbench top for the preemptive priority scheduler.
// Drives a directed sequence and three random phases with different sender
// gaps; the checker beside the block predicts and compares every result, and
// this module gives the verdict.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_tb;
  import pps_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 533;
  localparam int TAIL_CYCLES  = 8;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  in_t  in_data;
  logic busy;
  logic out_valid;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   idle_pct [3] = '{32, 79, 0};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  preemptive_priority_scheduler DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  preemptive_priority_scheduler_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic in_t admit_item(int id, int len, int pr);
    in_t it;
    it.func      = FN_ADMIT;
    it.task_id   = id[ID_W-1:0];
    it.burst_len = len[LEN_W-1:0];
    it.task_prio = pr[PRIO_W-1:0];
    return it;
  endfunction

  // id, burst and priority are noise on a tick
  function automatic in_t tick_item();
    in_t it;
    it.func      = FN_TICK;
    it.task_id   = ID_W'($urandom_range(15));
    it.burst_len = LEN_W'($urandom_range(16'hFFFF));
    it.task_prio = PRIO_W'($urandom_range(8'hFF));
    return it;
  endfunction

  function automatic in_t random_item();
    int sel;
    int len;
    int pr;
    sel = $urandom_range(99);
    if ($urandom_range(99) < 60)
      return tick_item();
    if (sel < 95)      len = $urandom_range(0, 3);
    else if (sel < 99) len = $urandom_range(4, 40);
    else               len = $urandom_range(16'hFFFF);
    pr = ($urandom_range(99) < 70) ? $urandom_range(0, 3) : $urandom_range(8'hFF);
    return admit_item($urandom_range(15), len, pr);
  endfunction

  task automatic send(in_t it);
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic hold_off(int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle tick, reject, zero burst, tie hold, lowest id, preemption
    send(tick_item());
    send(admit_item(0, 1, 0));
    send(admit_item(0, 3, 5));
    send(tick_item());
    send(admit_item(15, 0, 255));
    send(admit_item(3, 2, 7));
    send(admit_item(4, 2, 7));
    send(tick_item());
    send(tick_item());
    send(admit_item(1, 1, 7));
    send(tick_item());
    send(tick_item());
    send(tick_item());
    send(tick_item());
    send(admit_item(6, 3, 1));
    send(tick_item());
    send(admit_item(7, 1, 200));
    send(tick_item());
    send(tick_item());
    send(tick_item());
    send(tick_item());
    drain();

    foreach (idle_pct[p]) begin
      repeat (PHASE_ITEMS) begin
        send(random_item());
        hold_off(idle_pct[p]);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
src/pps_pkg.sv
src/pps_slot.sv
src/pps_pick.sv
src/preemptive_priority_scheduler.sv
sim/preemptive_priority_scheduler_chk.sv
sim/preemptive_priority_scheduler_tb.sv
